// ===== rtl/mctw_pkg.sv =====
// Package for the multi-channel task watchdog.
// Shared constants, register indexes and the channel-store write command.
// No dependencies.
package mctw_pkg;

    // Channel count and derived index width
    localparam int NUM_CHANNELS = 8;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Field widths
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int CHAN_W    = 3;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Beat widths (packed fields rounded up to whole bytes)
    localparam int S_DATA_W = 40;   // channel, now_ms
    localparam int M_DATA_W = 40;   // all_ok, expired_channel, feed_count

    // Timeout used when the register holds zero
    localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT = TIME_W'(3000);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MASK    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ARMED   = CFG_IDX_W'(2);

    // Command codes carried in s_tuser
    localparam logic CMD_FEED  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Write command into the per-channel store
    typedef struct packed {
        logic                feed;      // count up, store time, mark fed
        logic                baseline;  // store time, mark fed
        logic [CH_IDX_W-1:0] idx;
        logic [TIME_W-1:0]   now;
    } mctw_wr_t;

endpackage

// ===== rtl/multi_channel_task_watchdog.sv =====
// Multi-channel task watchdog, top level.
// Instantiates mctw_chan_store and mctw_cmp_unit; depends on mctw_pkg.
//
// Usage:
//   s_* channel: one beat per command. s_tuser is the command (0 feed, 1 check),
//   s_tdata holds the channel and the time in milliseconds.
//   m_* channel: exactly one result beat per command: all_ok, the first expired
//   channel and, for a feed, the channel's feed count after the feed.
//   cfg_* channel: register writes (timeout, enable mask, armed), always ready;
//   write only while no command is in flight.
// Sequencing:
//   A feed passes through ST_FEED and ST_OUT into the output register. A check
//   walks the channels one per cycle through a small sequencer; a fed, enabled
//   channel also passes through the shared elapsed-time comparator (ST_CMP),
//   and the walk stops at the first expired channel. One command is in work at
//   a time; s_tready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous): registers go to timeout 3000, mask 0,
//   armed 1; all channel times, counts and fed flags clear.
// Stall: the result sits in an output register; the next command is accepted
//   while it waits, and its own result is held until m_tready frees the
//   register.
module multi_channel_task_watchdog
    import mctw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Command stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [2:0] channel, [34:3] now_ms, rest zero
    input  logic                 s_tuser,   // [0] cmd
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [0] all_ok, [3:1] expired_channel,
                                            // [35:4] feed_count, rest zero
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_SCAN,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [TIME_W-1:0] timeout_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              armed_reg;

    // Latched command
    logic [CHAN_W-1:0] ch_reg;
    logic [TIME_W-1:0] now_reg;

    // Scan index and pending result
    logic [CH_IDX_W-1:0] idx_reg;
    logic                res_ok_reg;
    logic [CHAN_W-1:0]   res_ch_reg;
    logic [COUNT_W-1:0]  res_cnt_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Store and comparator connections
    mctw_wr_t            wr;
    logic [CH_IDX_W-1:0] rd_idx;
    logic [TIME_W-1:0]   rd_time;
    logic                rd_fed;
    logic [COUNT_W-1:0]  rd_count;
    logic [TIME_W-1:0]   limit;
    logic                cmp_expired;

    logic                ch_valid;
    logic                chan_en;
    logic                idx_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign limit    = (timeout_reg != '0) ? timeout_reg : DEFAULT_TIMEOUT;
    assign ch_valid = (32'(ch_reg) < 32'(NUM_CHANNELS));
    assign chan_en  = (32'(idx_reg) < 32'(MASK_W)) && mask_reg[3'(idx_reg)];
    assign idx_last = (32'(idx_reg) == 32'(NUM_CHANNELS - 1));

    // Store read address: fed channel during a feed, scan index otherwise
    assign rd_idx = (state_reg == ST_FEED) ? CH_IDX_W'(ch_reg) : idx_reg;

    // Store write command
    always_comb begin
        wr          = '0;
        wr.idx      = rd_idx;
        wr.now      = now_reg;
        wr.feed     = (state_reg == ST_FEED) && armed_reg && ch_valid;
        wr.baseline = (state_reg == ST_SCAN) && armed_reg && chan_en && !rd_fed;
    end

    mctw_chan_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rd_idx   (rd_idx),
        .rd_time  (rd_time),
        .rd_fed   (rd_fed),
        .rd_count (rd_count)
    );

    mctw_cmp_unit u_cmp (
        .aclk    (aclk),
        .now     (now_reg),
        .last    (rd_time),
        .limit   (limit),
        .expired (cmp_expired)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= DEFAULT_TIMEOUT;
            mask_reg    <= '0;
            armed_reg   <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data[TIME_W-1:0];
                REG_MASK:    mask_reg    <= cfg_data[MASK_W-1:0];
                REG_ARMED:   armed_reg   <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            // Drain the output beat; ST_OUT reloads it on its own
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ch_reg      <= s_tdata[CHAN_W-1:0];
                        now_reg     <= s_tdata[CHAN_W +: TIME_W];
                        idx_reg     <= '0;
                        res_ok_reg  <= 1'b1;
                        res_ch_reg  <= '0;
                        res_cnt_reg <= '0;
                        state_reg   <= (s_tuser == CMD_CHECK) ? ST_SCAN : ST_FEED;
                    end
                end
                ST_FEED: begin
                    if (armed_reg && ch_valid) begin
                        res_cnt_reg <= rd_count + COUNT_W'(1);
                    end
                    state_reg <= ST_OUT;
                end
                ST_SCAN: begin
                    if (!armed_reg) begin
                        state_reg <= ST_OUT;
                    end else if (chan_en && rd_fed) begin
                        state_reg <= ST_CMP;
                    end else if (idx_last) begin
                        state_reg <= ST_OUT;
                    end else begin
                        idx_reg <= idx_reg + CH_IDX_W'(1);
                    end
                end
                ST_CMP: begin
                    if (cmp_expired) begin
                        res_ok_reg <= 1'b0;
                        res_ch_reg <= CHAN_W'(idx_reg);
                        state_reg  <= ST_OUT;
                    end else if (idx_last) begin
                        state_reg <= ST_OUT;
                    end else begin
                        idx_reg   <= idx_reg + CH_IDX_W'(1);
                        state_reg <= ST_SCAN;
                    end
                end
                ST_OUT: begin
                    // Load once the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(M_DATA_W - COUNT_W - CHAN_W - 1){1'b0}},
                                         res_cnt_reg, res_ch_reg, res_ok_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/mctw_chan_store.sv =====
// Per-channel state of the watchdog: last feed time, fed flag, feed count.
// One read address, one write command per cycle. Depends on mctw_pkg.
module mctw_chan_store
    import mctw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  mctw_wr_t            wr,
    input  logic [CH_IDX_W-1:0] rd_idx,
    output logic [TIME_W-1:0]   rd_time,
    output logic                rd_fed,
    output logic [COUNT_W-1:0]  rd_count
);

    logic [TIME_W-1:0]  time_reg  [NUM_CHANNELS];
    logic [COUNT_W-1:0] count_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] fed_reg;

    // Read side
    assign rd_time  = time_reg[rd_idx];
    assign rd_count = count_reg[rd_idx];
    assign rd_fed   = fed_reg[rd_idx];

    // Update on feed or baseline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fed_reg <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                time_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end else begin
            if (wr.feed || wr.baseline) begin
                time_reg[wr.idx] <= wr.now;
                fed_reg[wr.idx]  <= 1'b1;
            end
            if (wr.feed) begin
                count_reg[wr.idx] <= count_reg[wr.idx] + COUNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/mctw_cmp_unit.sv =====
// Shared elapsed-time compare: (now - last) mod 2^32 > limit, registered.
// Used once per fed, enabled channel during a check. Depends on mctw_pkg.
module mctw_cmp_unit
    import mctw_pkg::*;
(
    input  logic              aclk,
    input  logic [TIME_W-1:0] now,
    input  logic [TIME_W-1:0] last,
    input  logic [TIME_W-1:0] limit,
    output logic              expired
);

    logic [TIME_W-1:0] elapsed;
    logic              expired_reg;

    // Wrapping subtract then compare
    assign elapsed = now - last;

    always_ff @(posedge aclk) begin
        expired_reg <= (elapsed > limit);
    end

    assign expired = expired_reg;

endmodule

// ===== rtl/mctw_checker.sv =====
// Port-level checks for the multi-channel task watchdog, bound to the top.
// Depends on mctw_pkg and multi_channel_task_watchdog.
module mctw_checker
    import mctw_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A nonzero feed count only comes with all_ok
    a_count_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[35:4] != '0) |-> m_tdata[0])
        else $error("feed count with all_ok low");

    // An ok result names no channel
    a_ok_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[3:1] == '0))
        else $error("expired channel set on ok result");

    // One command in work at a time
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while busy");

endmodule

bind multi_channel_task_watchdog mctw_checker u_mctw_checker (.*);
